// File: rtl/ptt_pkg.sv
// Shared constants, types and the arctangent table of the pan/tilt tracker.
package ptt_pkg;

  localparam int CORDIC_STEPS = 20;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int VAL_W   = 32;
  localparam int GAIN_W  = 24;
  localparam int RATE_W  = 31;
  localparam int AGE_W   = 16;
  localparam int TIME_W  = 24;

  // CORDIC datapath: vectors normalized to [2^40, 2^41), angle in Q2.30 plus pi offset
  localparam int CW       = 46;
  localparam int ZW       = 36;
  localparam int NORM_BIT = 40;
  localparam int ITER_W   = 6;
  localparam logic signed [CW-1:0] NORM_MIN = 46'sd1 <<< NORM_BIT;
  localparam logic signed [ZW-1:0] PI_Q30   = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Z_ROUND  = 36'sd8192;

  // serial multiply and divide
  localparam int MUL_BITS = 24;
  localparam int ACC_W    = 64;
  localparam int REM_W    = 25;

  localparam logic [TIME_W-1:0] RESET_MOVE_US = 24'd100000;
  localparam logic [TIME_W-1:0] US_PER_S      = 24'd1000000;

  typedef enum logic [2:0] {
    REG_GAIN_P_PAN  = 3'd0,
    REG_GAIN_P_TILT = 3'd1,
    REG_GAIN_D_PAN  = 3'd2,
    REG_GAIN_D_TILT = 3'd3,
    REG_RATE_LIMIT  = 3'd4,
    REG_DEADBAND    = 3'd5,
    REG_STALE_LIMIT = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {T_IDLE, T_ANGLE, T_AXIS, T_WB} top_state_t;
  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_DONE} cordic_state_t;
  typedef enum logic [3:0] {
    A_IDLE, A_MUL_P, A_MUL_D, A_MUL_M, A_DIV_D, A_SUM, A_MUL_S, A_DIV_S, A_DONE
  } axis_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [RATE_W-1:0] rate_limit;
    logic [RATE_W-1:0] deadband;
  } axis_cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] err;
    logic signed [VAL_W-1:0] prev;
    logic signed [VAL_W-1:0] pos;
    logic [TIME_W-1:0]       dt;
  } axis_in_t;

  // atan(2^-i) in Q2.30
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/ptt_if.sv
// Valid/ready channel interfaces for tracker items and commands.
interface ptt_item_if;
  import ptt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] vec_x;
  logic signed [VAL_W-1:0] vec_y;
  logic signed [VAL_W-1:0] vec_z;
  logic [AGE_W-1:0]        object_age_ms;
  logic [TIME_W-1:0]       elapsed_us;
  logic signed [VAL_W-1:0] pan_now;
  logic signed [VAL_W-1:0] tilt_now;

  modport source (output valid, vec_x, vec_y, vec_z, object_age_ms, elapsed_us,
                  pan_now, tilt_now, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, object_age_ms, elapsed_us,
                pan_now, tilt_now, output ready);
endinterface

interface ptt_result_if;
  import ptt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pan_target;
  logic signed [VAL_W-1:0] tilt_target;
  logic [TIME_W-1:0]       move_time_us;
  logic                    is_reset;

  modport source (output valid, pan_target, tilt_target, move_time_us, is_reset,
                  input ready);
  modport sink (input valid, pan_target, tilt_target, move_time_us, is_reset,
                output ready);
endinterface

// File: rtl/ptt_cordic.sv
// Iterative vectoring CORDIC giving atan2(ny, dx) in Q16.16 radians.
module ptt_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ptt_pkg::VAL_W-1:0]  ny,
  input  logic signed [ptt_pkg::VAL_W-1:0]  dx,
  output logic                              done,
  output logic signed [ptt_pkg::VAL_W-1:0]  angle
);
  import ptt_pkg::*;

  cordic_state_t state, state_next;
  logic signed [CW-1:0] x, y, ddx, ddy, ymag, m;
  logic signed [ZW-1:0] z, z_step, z_round, tab;
  logic [ITER_W-1:0]    i;
  logic                 norm_done, iter_last, zero_vec;

  assign zero_vec  = (dx == '0) && (ny == '0);
  assign ymag      = y[CW-1] ? -y : y;
  assign m         = (x > ymag) ? x : ymag;
  assign norm_done = m >= NORM_MIN;
  assign ddx       = y >>> i;
  assign ddy       = x >>> i;
  assign tab       = $signed({4'b0, atan_entry(i[4:0])});
  assign iter_last = i == ITER_W'(CORDIC_STEPS - 1);
  assign z_step    = (y > 0) ? z + tab : z - tab;
  assign z_round   = z_step + Z_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      C_IDLE: begin
        if (start) begin
          state_next = zero_vec ? C_DONE : C_NORM;
        end
      end
      C_NORM: begin
        if (norm_done) begin
          state_next = C_ITER;
        end
      end
      C_ITER: begin
        if (iter_last) begin
          state_next = C_DONE;
        end
      end
      C_DONE: begin
        done       = 1'b1;
        state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          i <= '0;
          if (zero_vec) begin
            angle <= '0;
          end
          // left half plane: rotate by pi first
          if (dx < 0) begin
            z <= (ny >= 0) ? PI_Q30 : -PI_Q30;
            x <= -CW'(dx);
            y <= -CW'(ny);
          end else begin
            z <= '0;
            x <= CW'(dx);
            y <= CW'(ny);
          end
        end
      end
      C_NORM: begin
        if (!norm_done) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      C_ITER: begin
        if (y > 0) begin
          x <= x + ddx;
          y <= y - ddy;
        end else begin
          x <= x - ddx;
          y <= y + ddy;
        end
        z <= z_step;
        i <= i + 1'b1;
        if (iter_last) begin
          angle <= 32'(z_round >>> 14);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/ptt_axis.sv
// One axis of the PD law: shift-add multiplies and restoring divides, one bit a cycle.
module ptt_axis (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  ptt_pkg::axis_in_t                 in_data,
  input  ptt_pkg::axis_cfg_t                cfg,
  output logic                              done,
  output logic signed [ptt_pkg::VAL_W-1:0]  target
);
  import ptt_pkg::*;

  axis_state_t state, state_next;

  logic [ACC_W-1:0]    acc, mcand, acc_add, num, quot;
  logic [MUL_BITS-1:0] mplier;
  logic [4:0]          mcnt;
  logic [5:0]          dcnt;
  logic [REM_W-1:0]    rem, rem_sh, rem_next;
  logic [TIME_W-1:0]   divisor, dt;
  logic                qbit, mul_last, div_last;

  logic                    err_neg, diff_neg, rate_neg;
  logic [31:0]             err_mag, err_mag_in, rate_mag;
  logic [32:0]             diff_mag, diff_mag_in;
  logic signed [32:0]      diff_in;
  logic [42:0]             pmag;
  logic [62:0]             dmag;
  logic signed [VAL_W-1:0] pos, rate, sat;
  logic signed [65:0]      p_s, d_s, sum, lim_s, sum_c;
  logic signed [39:0]      step_s, t_full;

  assign mul_last = mcnt == 5'(MUL_BITS - 1);
  assign div_last = dcnt == 6'(ACC_W - 1);
  assign acc_add  = acc + (mplier[0] ? mcand : '0);

  assign rem_sh   = {rem[REM_W-2:0], num[ACC_W-1]};
  assign qbit     = rem_sh >= {1'b0, divisor};
  assign rem_next = qbit ? rem_sh - {1'b0, divisor} : rem_sh;
  assign quot     = {num[ACC_W-2:0], qbit};

  assign err_mag_in  = in_data.err[VAL_W-1] ? 32'(-in_data.err) : 32'(in_data.err);
  assign diff_in     = {in_data.err[VAL_W-1], in_data.err}
                     - {in_data.prev[VAL_W-1], in_data.prev};
  assign diff_mag_in = diff_in[32] ? 33'(-diff_in) : 33'(diff_in);

  // P + D, clamp to +-limit, floor to Q16.16, deadband
  assign p_s   = err_neg ? -$signed({23'b0, pmag}) : $signed({23'b0, pmag});
  assign d_s   = diff_neg ? -$signed({3'b0, dmag}) : $signed({3'b0, dmag});
  assign sum   = p_s + d_s;
  assign lim_s = $signed({19'b0, cfg.rate_limit, 16'b0});
  assign sum_c = (sum > lim_s) ? lim_s : ((sum < -lim_s) ? -lim_s : sum);
  assign rate  = (err_mag < {1'b0, cfg.deadband}) ? '0 : $signed(sum_c[47:16]);
  assign rate_mag = rate[VAL_W-1] ? 32'(-rate) : 32'(rate);

  // position plus step, saturated
  assign step_s = rate_neg ? -$signed({1'b0, quot[38:0]}) : $signed({1'b0, quot[38:0]});
  assign t_full = step_s + $signed({{8{pos[VAL_W-1]}}, pos});
  assign sat    = (t_full > 40'sd2147483647) ? 32'sh7FFFFFFF :
                  (t_full < -40'sd2147483648) ? 32'sh80000000 : $signed(t_full[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      A_IDLE:  if (start) state_next = A_MUL_P;
      A_MUL_P: if (mul_last) state_next = A_MUL_D;
      A_MUL_D: if (mul_last) state_next = A_MUL_M;
      A_MUL_M: if (mul_last) state_next = A_DIV_D;
      A_DIV_D: if (div_last) state_next = A_SUM;
      A_SUM:   state_next = A_MUL_S;
      A_MUL_S: if (mul_last) state_next = A_DIV_S;
      A_DIV_S: if (div_last) state_next = A_DONE;
      A_DONE: begin
        done       = 1'b1;
        state_next = A_IDLE;
      end
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (start) begin
          err_neg  <= in_data.err[VAL_W-1];
          err_mag  <= err_mag_in;
          diff_neg <= diff_in[32];
          diff_mag <= diff_mag_in;
          dt       <= in_data.dt;
          pos      <= in_data.pos;
          acc      <= '0;
          mcand    <= {32'b0, err_mag_in};
          mplier   <= cfg.kp;
          mcnt     <= '0;
        end
      end
      A_MUL_P, A_MUL_D, A_MUL_M, A_MUL_S: begin
        acc    <= acc_add;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        mcnt   <= mcnt + 1'b1;
        if (mul_last) begin
          acc  <= '0;
          mcnt <= '0;
          rem  <= '0;
          dcnt <= '0;
          case (state)
            A_MUL_P: begin
              pmag   <= acc_add[42:0];
              mcand  <= {31'b0, diff_mag};
              mplier <= cfg.kd;
            end
            A_MUL_D: begin
              mcand  <= acc_add;
              mplier <= US_PER_S;
            end
            A_MUL_M: begin
              num     <= acc_add;
              divisor <= dt;
            end
            default: begin
              num     <= acc_add;
              divisor <= US_PER_S;
            end
          endcase
        end
      end
      A_DIV_D, A_DIV_S: begin
        num  <= quot;
        rem  <= rem_next;
        dcnt <= dcnt + 1'b1;
        if (div_last) begin
          if (state == A_DIV_D) begin
            dmag <= quot[62:0];
          end else begin
            target <= sat;
          end
        end
      end
      A_SUM: begin
        rate_neg <= rate[VAL_W-1];
        acc      <= '0;
        mcand    <= {32'b0, rate_mag};
        mplier   <= dt;
        mcnt     <= '0;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/pan_tilt_pd_tracker.sv
// Top level of the two-axis pan/tilt PD tracker with APB register port.
// Sequence: a tracked item passes through the two CORDICs in parallel, then the two axes.
//   Each CORDIC normalizes its vector by left shifts and then runs 20 iterations;
//   a zero vector skips both. Each axis then runs four shift-add multiplies and two
//   restoring divides, and the command is loaded into the output register.
// Items: one item at a time; the next item is taken once the command sits in the
//   output register. A stale item skips the angle and axis units.
// Reset: registers take their defaults, tracking off, first sample pending; no clear sweep.
module pan_tilt_pd_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptt_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptt_pkg::DATA_W-1:0]   pwdata,
  output logic [ptt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  ptt_item_if.sink                     item,
  ptt_result_if.source                 result
);
  import ptt_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0] gain_p_pan, gain_p_tilt, gain_d_pan, gain_d_tilt;
  logic [RATE_W-1:0] rate_limit, deadband;
  logic [AGE_W-1:0]  stale_limit_ms;
  cfg_reg_t          reg_idx;
  logic              cfg_wr;

  top_state_t state, state_next;
  logic       accept, stale, angle_start, axis_start, load;
  logic       tracking, first_sample;
  logic       pan_ok, tilt_ok, ax_pan_ok, ax_tilt_ok;
  logic       res_reset;

  logic signed [VAL_W-1:0] pe, te, prev_pe, prev_te, pan_r, tilt_r;
  logic [TIME_W-1:0]       el_r, dt_r;

  logic                    pan_c_done, tilt_c_done, pan_a_done, tilt_a_done;
  logic signed [VAL_W-1:0] pan_angle, tilt_angle, pan_tgt, tilt_tgt;
  axis_in_t                pan_in, tilt_in;
  axis_cfg_t               pan_cfg, tilt_cfg;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p_pan     <= 24'd262144;
      gain_p_tilt    <= 24'd196608;
      gain_d_pan     <= 24'd655;
      gain_d_tilt    <= 24'd655;
      rate_limit     <= 31'd19661;
      deadband       <= 31'd1144;
      stale_limit_ms <= 16'd5000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_P_PAN:  gain_p_pan     <= pwdata[GAIN_W-1:0];
        REG_GAIN_P_TILT: gain_p_tilt    <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_PAN:  gain_d_pan     <= pwdata[GAIN_W-1:0];
        REG_GAIN_D_TILT: gain_d_tilt    <= pwdata[GAIN_W-1:0];
        REG_RATE_LIMIT:  rate_limit     <= pwdata[RATE_W-1:0];
        REG_DEADBAND:    deadband       <= pwdata[RATE_W-1:0];
        REG_STALE_LIMIT: stale_limit_ms <= pwdata[AGE_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P_PAN:  prdata = DATA_W'(gain_p_pan);
      REG_GAIN_P_TILT: prdata = DATA_W'(gain_p_tilt);
      REG_GAIN_D_PAN:  prdata = DATA_W'(gain_d_pan);
      REG_GAIN_D_TILT: prdata = DATA_W'(gain_d_tilt);
      REG_RATE_LIMIT:  prdata = DATA_W'(rate_limit);
      REG_DEADBAND:    prdata = DATA_W'(deadband);
      REG_STALE_LIMIT: prdata = DATA_W'(stale_limit_ms);
      default:         prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign accept      = item.valid && item.ready;
  assign stale       = item.object_age_ms > stale_limit_ms;
  assign angle_start = accept && !stale;
  assign axis_start  = (state == T_ANGLE) && pan_ok && tilt_ok;
  // output register frees up when empty or being drained this cycle
  assign load        = (state == T_WB) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    unique case (state)
      T_IDLE: begin
        item.ready = 1'b1;
        if (accept) begin
          if (!stale) begin
            state_next = T_ANGLE;
          end else if (tracking) begin
            state_next = T_WB;   // one return-to-zero command
          end
        end
      end
      T_ANGLE: if (pan_ok && tilt_ok) state_next = T_AXIS;
      T_AXIS:  if (ax_pan_ok && ax_tilt_ok) state_next = T_WB;
      T_WB:    if (load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // tracking state and done flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking     <= 1'b0;
      first_sample <= 1'b1;
      pan_ok       <= 1'b0;
      tilt_ok      <= 1'b0;
      ax_pan_ok    <= 1'b0;
      ax_tilt_ok   <= 1'b0;
      prev_pe      <= '0;
      prev_te      <= '0;
    end else begin
      if (accept) begin
        tracking <= !stale;
      end
      if (angle_start) begin
        pan_ok  <= 1'b0;
        tilt_ok <= 1'b0;
      end else begin
        if (pan_c_done)  pan_ok  <= 1'b1;
        if (tilt_c_done) tilt_ok <= 1'b1;
      end
      if (axis_start) begin
        ax_pan_ok    <= 1'b0;
        ax_tilt_ok   <= 1'b0;
        // axes latch prev at this edge; from here on prev is this step's error
        prev_pe      <= pe;
        prev_te      <= te;
        first_sample <= 1'b0;
      end else begin
        if (pan_a_done)  ax_pan_ok  <= 1'b1;
        if (tilt_a_done) ax_tilt_ok <= 1'b1;
      end
    end
  end

  // item payload and angles
  always_ff @(posedge clk) begin
    if (accept) begin
      el_r      <= item.elapsed_us;
      dt_r      <= (item.elapsed_us == '0) ? TIME_W'(1) : item.elapsed_us;
      pan_r     <= item.pan_now;
      tilt_r    <= item.tilt_now;
      res_reset <= stale;
    end
    if (pan_c_done)  pe <= -pan_angle;
    if (tilt_c_done) te <= tilt_angle;
  end

  // ---------------- angle units ----------------
  ptt_cordic u_cordic_pan (
    .clk   (clk),
    .rst   (rst),
    .start (angle_start),
    .ny    (item.vec_x),
    .dx    (item.vec_z),
    .done  (pan_c_done),
    .angle (pan_angle)
  );

  ptt_cordic u_cordic_tilt (
    .clk   (clk),
    .rst   (rst),
    .start (angle_start),
    .ny    (item.vec_y),
    .dx    (item.vec_z),
    .done  (tilt_c_done),
    .angle (tilt_angle)
  );

  // ---------------- PD axes ----------------
  // first sample: previous error equals current, so the D term vanishes
  assign pan_in.err  = pe;
  assign pan_in.prev = first_sample ? pe : prev_pe;
  assign pan_in.pos  = pan_r;
  assign pan_in.dt   = dt_r;

  assign tilt_in.err  = te;
  assign tilt_in.prev = first_sample ? te : prev_te;
  assign tilt_in.pos  = tilt_r;
  assign tilt_in.dt   = dt_r;

  assign pan_cfg.kp          = gain_p_pan;
  assign pan_cfg.kd          = gain_d_pan;
  assign pan_cfg.rate_limit  = rate_limit;
  assign pan_cfg.deadband    = deadband;
  assign tilt_cfg.kp         = gain_p_tilt;
  assign tilt_cfg.kd         = gain_d_tilt;
  assign tilt_cfg.rate_limit = rate_limit;
  assign tilt_cfg.deadband   = deadband;

  ptt_axis u_axis_pan (
    .clk     (clk),
    .rst     (rst),
    .start   (axis_start),
    .in_data (pan_in),
    .cfg     (pan_cfg),
    .done    (pan_a_done),
    .target  (pan_tgt)
  );

  ptt_axis u_axis_tilt (
    .clk     (clk),
    .rst     (rst),
    .start   (axis_start),
    .in_data (tilt_in),
    .cfg     (tilt_cfg),
    .done    (tilt_a_done),
    .target  (tilt_tgt)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.valid && result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.pan_target   <= res_reset ? '0 : pan_tgt;
      result.tilt_target  <= res_reset ? '0 : tilt_tgt;
      result.move_time_us <= res_reset ? RESET_MOVE_US : el_r;
      result.is_reset     <= res_reset;
    end
  end

endmodule

// File: rtl/ptt_checker.sv
// Port-level assertions for the tracker and the bind that attaches them.
module ptt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [ptt_pkg::VAL_W-1:0]  pan_target,
  input logic signed [ptt_pkg::VAL_W-1:0]  tilt_target,
  input logic [ptt_pkg::TIME_W-1:0]        move_time_us,
  input logic                              is_reset
);
  import ptt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("command valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("command dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(pan_target) && $stable(tilt_target)
      && $stable(move_time_us) && $stable(is_reset))
    else $error("command changed while stalled");

  a_reset_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_reset |-> pan_target == '0 && tilt_target == '0
      && move_time_us == RESET_MOVE_US)
    else $error("bad return-to-zero command");

  a_single_reset: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && is_reset |=> !(result_valid && is_reset))
    else $error("two return-to-zero commands in a row");

endmodule

bind pan_tilt_pd_tracker ptt_checker u_ptt_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .pan_target   (result.pan_target),
  .tilt_target  (result.tilt_target),
  .move_time_us (result.move_time_us),
  .is_reset     (result.is_reset)
);
